// File: hdl/salc_pkg.sv
// Shared types and constants for the set-associative LRU cache model.
// Access codes, register indexes, controller states and reset values.
// No dependencies.
`default_nettype none

package salc_pkg;

   localparam int RANK_W   = 8;
   localparam int RANK_MAX = 255;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 4;
   localparam int CB_W    = 16;
   localparam int FETCH_W = 5;

   typedef enum logic [1:0] {
      FUNC_LOAD  = 2'd0,
      FUNC_STORE = 2'd1,
      FUNC_FETCH = 2'd2,
      FUNC_FLUSH = 2'd3
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SPLIT      = 3'd0,
      REG_BLOCK_LOG2 = 3'd1,
      REG_DSETS_LOG2 = 3'd2,
      REG_ISETS_LOG2 = 3'd3,
      REG_WAYS       = 3'd4,
      REG_WRITE_BACK = 3'd5,
      REG_WRITE_ALLOC = 3'd6,
      REG_NONE       = 3'd7
   } reg_idx_type;

   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_LOOK   = 7'b0000100,
      ST_FLUSH  = 7'b0001000,
      ST_FDRAIN = 7'b0010000,
      ST_FOUT   = 7'b0100000,
      ST_SPARE  = 7'b1000000
   } state_type;

   localparam logic       RST_SPLIT      = 1'b0;
   localparam logic [2:0] RST_BLOCK_LOG2 = 3'd4;
   localparam logic [3:0] RST_SETS_LOG2  = 4'd9;
   localparam logic [2:0] RST_WAYS       = 3'd1;
   localparam logic       RST_WB         = 1'b1;
   localparam logic       RST_WA         = 1'b1;

endpackage

`default_nettype wire

// File: hdl/set_assoc_lru_cache_model.sv
// Set-associative LRU cache model: tag stores in two synchronous row memories.
// Load/store/fetch: the set row is read into a register, then updated and the result
// registered once the output is free. Flush: walks every data set in use, one row a cycle.
// After reset a clearing pass over all MAX_SETS rows zeroes both memories; no request
// beat is taken then. Configuration beats are taken at any time. Depends on salc_pkg.
`default_nettype none

module set_assoc_lru_cache_model #(
   parameter int MAX_WAYS  = 4,
   parameter int MAX_SETS  = 512,
   parameter int ADDR_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // address[31:0]
   input  wire logic [1:0]  req_tuser,   // func[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // hit[0], replaced[1], fetch_words[6:2], copyback_words[22:7], zero[23]
   output logic [23:0]      rsp_tdata,
   output logic             rsp_tuser,   // stat_class[0]
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [salc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [salc_pkg::CSR_DATA_W-1:0] csr_data
);
   import salc_pkg::*;

   localparam int IDX_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int SB_MAX  = $clog2(MAX_SETS + 1) - 1;
   localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WCNT_W  = $clog2(MAX_WAYS + 1);
   localparam int TAG_W   = ADDR_BITS - 2;
   localparam int ACC_W   = $clog2(MAX_SETS * MAX_WAYS * 16 + 1);
   localparam int PCNT_W  = $clog2(MAX_WAYS + 1);

   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic              valid;
      logic              dirty;
      logic [RANK_W-1:0] rank;
   } line_type;

   typedef line_type [MAX_WAYS-1:0] row_type;

   row_type main_mem [MAX_SETS];
   row_type inst_mem [MAX_SETS];

   logic       split_ff;
   logic [2:0] block_log2_ff;
   logic [3:0] dsets_log2_ff;
   logic [3:0] isets_log2_ff;
   logic [2:0] ways_ff;
   logic       wb_ff;
   logic       wa_ff;

   state_type state_ff, state_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic [1:0]       func_ff;
   logic             use_inst_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [TAG_W-1:0] tag_ff;
   row_type          main_rd_ff, inst_rd_ff;
   logic             fl_rd_ff;
   logic [ACC_W-1:0] acc_ff;
   logic             rsp_valid_ff;
   logic [23:0]      rsp_data_ff;
   logic             rsp_user_ff;

   // effective geometry
   logic [2:0]        off_eff;
   logic [3:0]        dsb_eff, isb_eff, sb_sel;
   logic [WCNT_W-1:0] ways_eff;
   logic [FETCH_W-1:0] words;

   always_comb begin
      off_eff = (block_log2_ff < 3'd2) ? 3'd2 : ((block_log2_ff > 3'd6) ? 3'd6 : block_log2_ff);
      dsb_eff = (32'(dsets_log2_ff) > SB_MAX) ? 4'(SB_MAX) : dsets_log2_ff;
      isb_eff = (32'(isets_log2_ff) > SB_MAX) ? 4'(SB_MAX) : isets_log2_ff;
      if (ways_ff == 3'd0) begin
         ways_eff = WCNT_W'(1);
      end else if (32'(ways_ff) > MAX_WAYS) begin
         ways_eff = WCNT_W'(MAX_WAYS);
      end else begin
         ways_eff = WCNT_W'(ways_ff);
      end
      words = FETCH_W'(1) << (off_eff - 3'd2);
   end

   // request decode
   logic       req_acc, req_inst, req_flush;
   logic [ADDR_BITS-1:0] addr;
   logic [IDX_W-1:0] req_idx;
   logic [TAG_W-1:0] req_tag;
   logic [ADDR_BITS-1:0] sh_idx;

   always_comb begin
      req_acc   = req_tvalid && req_tready;
      req_flush = (req_tuser == FUNC_FLUSH);
      req_inst  = (req_tuser == FUNC_FETCH) && split_ff;
      sb_sel    = req_inst ? isb_eff : dsb_eff;
      addr      = req_tdata[ADDR_BITS-1:0];
      sh_idx    = addr >> off_eff;
      req_idx   = sh_idx[IDX_W-1:0] & IDX_W'((64'd1 << sb_sel) - 64'd1);
      req_tag   = TAG_W'(addr >> (6'(off_eff) + 6'(sb_sel)));
   end

   // update of one set row
   row_type    row, row_new;
   logic [MAX_WAYS-1:0] inuse;
   logic       hit, free_found, is_store, no_alloc, fill, was_valid, repl;
   logic [WAY_W-1:0] hit_way, free_way, victim, way;
   logic [RANK_W-1:0] r;
   logic [CB_W-1:0] cb;
   logic       step_go;

   always_comb begin
      row        = use_inst_ff ? inst_rd_ff : main_rd_ff;
      row_new    = row;
      hit        = 1'b0;
      free_found = 1'b0;
      hit_way    = '0;
      free_way   = '0;
      victim     = '0;
      for (int i = 0; i < MAX_WAYS; i++) begin
         inuse[i] = (i < 32'(ways_eff));
      end
      for (int i = MAX_WAYS - 1; i >= 0; i--) begin
         if (inuse[i] && row[i].valid && row[i].tag == tag_ff) begin
            hit = 1'b1;
            hit_way = WAY_W'(i);
         end
         if (inuse[i] && !row[i].valid) begin
            free_found = 1'b1;
            free_way = WAY_W'(i);
         end
      end
      for (int i = 1; i < MAX_WAYS; i++) begin
         if (inuse[i] && row[i].rank > row[victim].rank) begin
            victim = WAY_W'(i);
         end
      end
      is_store  = (func_ff == FUNC_STORE);
      no_alloc  = !hit && is_store && !wa_ff;
      fill      = !hit && !no_alloc;
      way       = hit ? hit_way : (free_found ? free_way : victim);
      was_valid = hit || !free_found;
      repl      = fill && !free_found;
      r         = row[way].rank;
      cb        = '0;
      if (no_alloc) begin
         cb = CB_W'(1);
      end
      if (repl && row[way].dirty && wb_ff && !use_inst_ff) begin
         cb = cb + CB_W'(words);
      end
      if (fill) begin
         row_new[way].tag   = tag_ff;
         row_new[way].valid = 1'b1;
         row_new[way].dirty = 1'b0;
      end
      if (is_store && !no_alloc) begin
         if (wb_ff) begin
            row_new[way].dirty = 1'b1;
         end else begin
            cb = cb + CB_W'(1);
         end
      end
      if (!no_alloc) begin
         for (int i = 0; i < MAX_WAYS; i++) begin
            if (inuse[i] && WAY_W'(i) != way && row[i].valid &&
                (!was_valid || row[i].rank < r) && row[i].rank != RANK_W'(RANK_MAX)) begin
               row_new[i].rank = row[i].rank + RANK_W'(1);
            end
         end
         row_new[way].rank = '0;
      end
      step_go = !rsp_valid_ff || rsp_tready;
   end

   // flush count of one row
   logic [PCNT_W-1:0] pcnt;
   logic [ACC_W-1:0]  row_words;
   logic [CB_W-1:0]   flush_cb;

   always_comb begin
      pcnt = '0;
      for (int i = 0; i < MAX_WAYS; i++) begin
         if (inuse[i] && main_rd_ff[i].valid && main_rd_ff[i].dirty) begin
            pcnt = pcnt + PCNT_W'(1);
         end
      end
      row_words = ACC_W'(pcnt) << (off_eff - 3'd2);
      flush_cb  = (acc_ff > ACC_W'(16'hFFFF)) ? 16'hFFFF : CB_W'(acc_ff);
   end

   // control
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_CLEAR: begin
            cnt_in = cnt_ff + IDX_W'(1);
            if (32'(cnt_ff) == MAX_SETS - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cnt_in = '0;
            if (req_acc) begin
               state_in = req_flush ? ST_FLUSH : ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (step_go) begin
               state_in = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            cnt_in = cnt_ff + IDX_W'(1);
            if (cnt_ff == IDX_W'((64'd1 << dsb_eff) - 64'd1)) begin
               state_in = ST_FDRAIN;
            end
         end
         ST_FDRAIN: state_in = ST_FOUT;
         ST_FOUT: begin
            if (step_go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
         fl_rd_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         split_ff <= RST_SPLIT;
         block_log2_ff <= RST_BLOCK_LOG2;
         dsets_log2_ff <= RST_SETS_LOG2;
         isets_log2_ff <= RST_SETS_LOG2;
         ways_ff <= RST_WAYS;
         wb_ff <= RST_WB;
         wa_ff <= RST_WA;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         fl_rd_ff <= (state_ff == ST_FLUSH);
         if ((state_ff == ST_LOOK || state_ff == ST_FOUT) && step_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            case (csr_index)
               REG_SPLIT:       split_ff <= csr_data[0];
               REG_BLOCK_LOG2:  block_log2_ff <= csr_data[2:0];
               REG_DSETS_LOG2:  dsets_log2_ff <= csr_data;
               REG_ISETS_LOG2:  isets_log2_ff <= csr_data;
               REG_WAYS:        ways_ff <= csr_data[2:0];
               REG_WRITE_BACK:  wb_ff <= csr_data[0];
               REG_WRITE_ALLOC: wa_ff <= csr_data[0];
               default: ;
            endcase
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_acc) begin
         func_ff     <= req_tuser;
         use_inst_ff <= req_inst;
         idx_ff      <= req_idx;
         tag_ff      <= req_tag;
         acc_ff      <= '0;
      end else if (fl_rd_ff) begin
         acc_ff <= acc_ff + row_words;
      end
      if (state_ff == ST_LOOK && step_go) begin
         rsp_user_ff <= (func_ff == FUNC_FETCH);
         rsp_data_ff <= {1'b0, cb, fill ? words : FETCH_W'(0), repl, hit};
      end else if (state_ff == ST_FOUT && step_go) begin
         rsp_user_ff <= 1'b0;
         rsp_data_ff <= {1'b0, flush_cb, FETCH_W'(0), 1'b0, 1'b0};
      end
   end

   // row memories
   logic [IDX_W-1:0] rd_addr;
   logic             rd_en;
   row_type          zero_row;

   always_comb begin
      rd_en   = req_acc || (state_ff == ST_FLUSH);
      rd_addr = (state_ff == ST_FLUSH) ? cnt_ff : req_idx;
      for (int i = 0; i < MAX_WAYS; i++) begin
         zero_row[i] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         main_rd_ff <= main_mem[rd_addr];
         inst_rd_ff <= inst_mem[rd_addr];
      end
      if (state_ff == ST_CLEAR) begin
         main_mem[cnt_ff] <= zero_row;
         inst_mem[cnt_ff] <= zero_row;
      end else if (state_ff == ST_LOOK && step_go) begin
         if (use_inst_ff) begin
            inst_mem[idx_ff] <= row_new;
         end else begin
            main_mem[idx_ff] <= row_new;
         end
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign csr_ready  = 1'b1;

   a_accept_look: assert property (@(posedge clock) disable iff (reset)
      (req_acc && !req_flush) |=> (state_ff == ST_LOOK))
      else $error("access not followed by lookup");
   a_no_take_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_tready)
      else $error("request taken during clearing pass");
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_LOOK || $past(state_ff) == ST_FOUT))
      else $error("response raised outside result states");
   a_flush_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FDRAIN) |-> fl_rd_ff)
      else $error("flush drain without pending row");

endmodule

`default_nettype wire

// File: test/tb.sv
// Testbench for set_assoc_lru_cache_model: directed and random cache accesses
// checked against a behavioral cache predictor kept in a scoreboard class.
// Depends on salc_pkg and the DUT.
`timescale 1ns / 1ps

module tb;
   import salc_pkg::*;

   localparam int NWAYS = 4;
   localparam int NSETS = 512;

   typedef struct packed {
      logic        cls;
      logic        hit;
      logic        repl;
      logic [4:0]  fetch;
      logic [15:0] cb;
   } access_rsp_type;

   class cache_scoreboard;
      logic [29:0] mtag [NSETS*NWAYS];
      bit          mval [NSETS*NWAYS];
      bit          mdirty [NSETS*NWAYS];
      int          mrank [NSETS*NWAYS];
      logic [29:0] itag [NSETS*NWAYS];
      bit          ival [NSETS*NWAYS];
      int          irank [NSETS*NWAYS];
      bit          split;
      int          blk_log2, dsets, isets, ways;
      bit          wb, wa;
      access_rsp_type pending[$];
      int          errors;

      function new();
         split = RST_SPLIT; blk_log2 = RST_BLOCK_LOG2; dsets = RST_SETS_LOG2;
         isets = RST_SETS_LOG2; ways = RST_WAYS; wb = RST_WB; wa = RST_WA;
         foreach (mval[i]) begin
            mval[i] = 0; mdirty[i] = 0; mrank[i] = 0;
            ival[i] = 0; irank[i] = 0;
         end
      endfunction

      function void write_reg(reg_idx_type idx, logic [3:0] v);
         case (idx)
            REG_SPLIT:       split = v[0];
            REG_BLOCK_LOG2:  blk_log2 = v[2:0];
            REG_DSETS_LOG2:  dsets = v;
            REG_ISETS_LOG2:  isets = v;
            REG_WAYS:        ways = v[2:0];
            REG_WRITE_BACK:  wb = v[0];
            REG_WRITE_ALLOC: wa = v[0];
            default: ;
         endcase
      endfunction

      function int offs();
         return blk_log2 < 2 ? 2 : (blk_log2 > 6 ? 6 : blk_log2);
      endfunction

      function int nways();
         return ways < 1 ? 1 : (ways > NWAYS ? NWAYS : ways);
      endfunction

      function int sbits(int s);
         return s > 9 ? 9 : s;
      endfunction

      function access_rsp_type do_access(bit inst, int setb, logic [31:0] addr,
                                         bit st);
         access_rsp_type r;
         int off, words, nw, idx, base, way, best, r0;
         logic [29:0] tg;
         bit fresh;
         off = offs(); words = 1 << (off - 2); nw = nways();
         idx = (addr >> off) & ((1 << setb) - 1);
         tg = 30'(64'(addr) >> (off + setb));
         base = idx * NWAYS;
         r = '0; way = 0;
         for (int i = 0; i < nw; i++) begin
            if (!r.hit && (inst ? ival[base+i] : mval[base+i])
                && (inst ? itag[base+i] : mtag[base+i]) == tg) begin
               r.hit = 1; way = i;
            end
         end
         if (!r.hit && st && !wa) begin
            r.cb = 1;
            return r;
         end
         fresh = 0;
         if (r.hit) begin
            if (st) begin
               if (wb) mdirty[base+way] = 1; else r.cb = 1;
            end
         end else begin
            r.fetch = 5'(words);
            for (int i = nw - 1; i >= 0; i--)
               if (!(inst ? ival[base+i] : mval[base+i])) begin
                  way = i; fresh = 1;
               end
            if (!fresh) begin
               best = 0;
               for (int i = 1; i < nw; i++)
                  if ((inst ? irank[base+i] : mrank[base+i])
                      > (inst ? irank[base+best] : mrank[base+best])) best = i;
               way = best; r.repl = 1;
               if (!inst && mdirty[base+way] && wb) r.cb = 16'(words);
            end
            if (inst) begin
               itag[base+way] = tg; ival[base+way] = 1;
            end else begin
               mtag[base+way] = tg; mval[base+way] = 1; mdirty[base+way] = 0;
               if (st) begin
                  if (wb) mdirty[base+way] = 1; else r.cb = r.cb + 16'd1;
               end
            end
         end
         r0 = inst ? irank[base+way] : mrank[base+way];
         for (int i = 0; i < nw; i++) begin
            if (i == way || !(inst ? ival[base+i] : mval[base+i])) continue;
            if (inst) begin
               if ((fresh || irank[base+i] < r0) && irank[base+i] < RANK_MAX)
                  irank[base+i]++;
            end else begin
               if ((fresh || mrank[base+i] < r0) && mrank[base+i] < RANK_MAX)
                  mrank[base+i]++;
            end
         end
         if (inst) irank[base+way] = 0; else mrank[base+way] = 0;
         return r;
      endfunction

      function void note_access(func_type f, logic [31:0] addr);
         access_rsp_type r;
         longint tot;
         r = '0;
         if (f == FUNC_FLUSH) begin
            tot = 0;
            for (int s = 0; s < (1 << sbits(dsets)); s++)
               for (int w = 0; w < nways(); w++)
                  if (mval[s*NWAYS+w] && mdirty[s*NWAYS+w])
                     tot += 1 << (offs() - 2);
            r.cb = tot > 65535 ? 16'hFFFF : tot[15:0];
         end else if (f == FUNC_FETCH) begin
            r = split ? do_access(1, sbits(isets), addr, 0)
                      : do_access(0, sbits(dsets), addr, 0);
            r.cls = 1;
         end else begin
            r = do_access(0, sbits(dsets), addr, f == FUNC_STORE);
         end
         pending.push_back(r);
      endfunction

      function void check_rsp(access_rsp_type got);
         access_rsp_type exp;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response %h", got);
            return;
         end
         exp = pending.pop_front();
         if (got !== exp) begin
            errors++;
            if (errors <= 10)
               $display("mismatch cls hit repl fetch cb: exp %0d %0d %0d %0d %0d, %s",
                        exp.cls, exp.hit, exp.repl, exp.fetch, exp.cb,
                        $sformatf("got %0d %0d %0d %0d %0d",
                                  got.cls, got.hit, got.repl, got.fetch, got.cb));
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   cache_scoreboard sb = new();
   bit calm;
   logic [31:0] hot_tags [8];

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   set_assoc_lru_cache_model dut (.*);

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            sb.check_rsp(access_rsp_type'({rsp_tuser, rsp_tdata[0], rsp_tdata[1],
                                           rsp_tdata[6:2], rsp_tdata[22:7]}));
         rsp_tready <= calm || ($urandom_range(99) >= 28);
      end
   end

   task automatic send_access(func_type f, logic [31:0] addr);
      while (!calm && $urandom_range(99) < 28) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1; req_tuser <= f; req_tdata <= addr;
      do @(posedge clock); while (!req_tready);
      sb.note_access(f, addr);
   endtask

   task automatic write_csr(reg_idx_type idx, logic [3:0] v);
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (NSETS + 20) @(posedge clock);
      csr_valid <= 1; csr_index <= idx; csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, v);
      csr_valid <= 0;
   endtask

   function automatic logic [31:0] pick_addr();
      logic [31:0] a;
      a = $urandom();
      if ($urandom_range(3) != 0)
         a = {hot_tags[$urandom_range(7)][31:12], a[11:0]};
      return a;
   endfunction

   task automatic run_phase(int n);
      int k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(99);
         send_access(k < 40 ? FUNC_LOAD : k < 75 ? FUNC_STORE : k < 97 ? FUNC_FETCH
                     : FUNC_FLUSH, pick_addr());
      end
   endtask

   initial begin
      #400000000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      foreach (hot_tags[i]) hot_tags[i] = $urandom();
      repeat (7) @(posedge clock);
      reset <= 0;
      calm = 0;
      send_access(FUNC_LOAD, 32'h0);
      send_access(FUNC_LOAD, 32'hFFFF_FFFF);
      send_access(FUNC_STORE, 32'hFFFF_FFFF);
      send_access(FUNC_STORE, 32'h0000_2000);
      send_access(FUNC_FETCH, 32'h0000_0000);
      send_access(FUNC_FETCH, 32'h8000_0000);
      send_access(FUNC_FLUSH, 32'hFFFF_FFFF);
      write_csr(REG_WAYS, 4'd4);
      write_csr(REG_DSETS_LOG2, 4'd0);
      for (int i = 0; i < 6; i++) send_access(FUNC_STORE, 32'(i) << 20);
      send_access(FUNC_LOAD, 32'h0000_0000);
      send_access(FUNC_FLUSH, 32'h0);
      write_csr(REG_WRITE_BACK, 4'd0);
      write_csr(REG_WRITE_ALLOC, 4'd0);
      send_access(FUNC_STORE, 32'h0700_0000);
      send_access(FUNC_STORE, 32'h0000_0004);
      write_csr(REG_SPLIT, 4'd1);
      write_csr(REG_ISETS_LOG2, 4'd15);
      write_csr(REG_BLOCK_LOG2, 4'd7);
      send_access(FUNC_FETCH, 32'h1234_5678);
      send_access(FUNC_FETCH, 32'h1234_5678);
      write_csr(REG_WAYS, 4'd0);
      write_csr(REG_BLOCK_LOG2, 4'd0);
      send_access(FUNC_LOAD, 32'h5555_AAAA);
      for (int p = 0; p < 9; p++) begin
         write_csr(REG_SPLIT, 4'($urandom_range(1)));
         write_csr(REG_BLOCK_LOG2, 4'($urandom_range(7)));
         write_csr(REG_DSETS_LOG2, 4'($urandom_range(15)));
         write_csr(REG_ISETS_LOG2, 4'($urandom_range(15)));
         write_csr(REG_WAYS, 4'($urandom_range(7)));
         write_csr(REG_WRITE_BACK, 4'($urandom_range(1)));
         write_csr(REG_WRITE_ALLOC, 4'($urandom_range(1)));
         foreach (hot_tags[i]) hot_tags[i] = $urandom();
         calm = (p == 4);
         run_phase(100);
      end
      calm = 0;
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (sb.errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule

// File: set_assoc_lru_cache_model.f
hdl/salc_pkg.sv
hdl/set_assoc_lru_cache_model.sv
test/tb.sv
